@@ sv/ipq_pkg.sv @@
// Shared constants, types and the priority lookup of the pending interrupt queue.
package ipq_pkg;

    // Queue geometry
    localparam int LIST_DEPTH    = 32;
    localparam int LEN_W         = $clog2(LIST_DEPTH + 1);
    localparam int VEC_W         = 5;
    localparam int VEC_COUNT     = 1 << VEC_W;
    localparam int NUM_VECTORS   = 32;
    localparam int PRIORITY_BITS = 4;
    localparam int PRIO_FIELD_W  = 4;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 1;

    localparam logic [VEC_W:0] NUM_VECTORS_L = (VEC_W + 1)'(NUM_VECTORS);
    localparam logic [LEN_W-1:0] LIST_DEPTH_L = LEN_W'(LIST_DEPTH);

    // Operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_HIGH = 1'b1;

    typedef logic [PRIORITY_BITS-1:0] prio_t;
    typedef logic [2*CFG_W-1:0] prio_cfg_t;

    // One list slot
    typedef struct packed {
        logic             valid;
        logic [VEC_W-1:0] vec;
    } entry_t;

    // Broadcast command to every cell; enables are already qualified
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [VEC_W-1:0] vec;
        prio_t            prio;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [VEC_W-1:0] popped_vector;
        logic             done_res;
        logic [LEN_W-1:0] pending_count;
    } result_t;

    // Look up the configured priority of a vector
    function automatic prio_t prio_of(input prio_cfg_t cfg, input logic [VEC_W-1:0] vec);
        logic [PRIO_FIELD_W-1:0] field;
        field = cfg[int'(vec) * PRIO_FIELD_W +: PRIO_FIELD_W];
        return field[PRIORITY_BITS-1:0];
    endfunction

endpackage

@@ sv/irq_pending_priority_queue.sv @@
// Top level of the pending interrupt priority queue: chain of list cells and result buffer.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  op, vector_number
//   out      output     out_valid/out_stall popped_vector, done_res, pending_count
//   cfg      input      cfg_we             cfg_index, cfg_data
//
// One item per cycle while the result buffer is not full: push, pop and clear each update
// the whole cell row together; the result goes into the result buffer and then to the output.
// The row update is set by the insert-position and remove-position ripple along the cells.
// Reset empties the list, clears the pending bits and zeroes both priority registers.
// A stalled output fills the two-entry result buffer, after which the input stalls.
module irq_pending_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic [ipq_pkg::VEC_W-1:0]           vector_number,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ipq_pkg::VEC_W-1:0]           popped_vector,
    output logic                                done_res,
    output logic [ipq_pkg::LEN_W-1:0]           pending_count,
    input  logic                                cfg_we,
    input  logic [ipq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ipq_pkg::CFG_W-1:0]           cfg_data
);

    logic [ipq_pkg::CFG_W-1:0]     prio_lo_reg;
    logic [ipq_pkg::CFG_W-1:0]     prio_hi_reg;
    ipq_pkg::prio_cfg_t            prio_cfg;
    logic [ipq_pkg::VEC_COUNT-1:0] pending_reg;
    logic [ipq_pkg::VEC_COUNT-1:0] pending_next;
    logic [ipq_pkg::LEN_W-1:0]     len_reg;
    logic [ipq_pkg::LEN_W-1:0]     len_next;

    logic             accept;
    logic             fifo_full;
    logic             vec_ok;
    logic             is_pending;
    logic             push_ok;
    logic             pop_ok;
    logic             clr_ok;
    logic [ipq_pkg::VEC_W-1:0] head_vec;
    ipq_pkg::cmd_t    cmd;
    ipq_pkg::result_t res;
    ipq_pkg::result_t out_res;

    ipq_pkg::entry_t                ent [ipq_pkg::LIST_DEPTH];
    logic [ipq_pkg::LIST_DEPTH:0]   ins_c;
    logic [ipq_pkg::LIST_DEPTH:0]   rm_c;
    logic [ipq_pkg::LIST_DEPTH-1:0] valid_vec;

    // Hold the priority registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_lo_reg <= '0;
            prio_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ipq_pkg::CFG_PRIO_LOW:  prio_lo_reg <= cfg_data;
                ipq_pkg::CFG_PRIO_HIGH: prio_hi_reg <= cfg_data;
                default:                prio_lo_reg <= prio_lo_reg;
            endcase
        end
    end

    assign prio_cfg = {prio_hi_reg, prio_lo_reg};

    // Qualify the operation
    assign in_stall   = fifo_full;
    assign accept     = in_valid && !fifo_full;
    assign vec_ok     = ({1'b0, vector_number} < ipq_pkg::NUM_VECTORS_L);
    assign is_pending = pending_reg[vector_number];
    assign head_vec   = ent[0].vec;
    assign push_ok    = accept && (op == ipq_pkg::OP_PUSH) && vec_ok && !is_pending
                        && (len_reg != ipq_pkg::LIST_DEPTH_L);
    assign pop_ok     = accept && (op == ipq_pkg::OP_POP) && (len_reg != '0);
    assign clr_ok     = accept && (op == ipq_pkg::OP_CLEAR) && vec_ok && is_pending;

    assign cmd.push  = push_ok;
    assign cmd.pop   = pop_ok;
    assign cmd.clear = clr_ok;
    assign cmd.vec   = vector_number;
    assign cmd.prio  = ipq_pkg::prio_of(prio_cfg, vector_number);

    // Row of list cells
    assign ins_c[0] = 1'b0;
    assign rm_c[0]  = 1'b0;

    for (genvar i = 0; i < ipq_pkg::LIST_DEPTH; i++)
    begin : g_cell
        ipq_pkg::entry_t left_e;
        ipq_pkg::entry_t right_e;
        if (i == 0)
        begin : g_first
            assign left_e = '0;
        end
        else
        begin : g_mid_l
            assign left_e = ent[i-1];
        end
        if (i == ipq_pkg::LIST_DEPTH - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_mid_r
            assign right_e = ent[i+1];
        end

        ipq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .prio_cfg (prio_cfg),
            .left_in  (left_e),
            .right_in (right_e),
            .ins_in   (ins_c[i]),
            .ins_out  (ins_c[i+1]),
            .rm_in    (rm_c[i]),
            .rm_out   (rm_c[i+1]),
            .slot     (ent[i])
        );

        assign valid_vec[i] = ent[i].valid;
    end

    // Update pending bits and length
    always_comb
    begin
        pending_next = pending_reg;
        len_next     = len_reg;
        if (push_ok)
        begin
            pending_next[vector_number] = 1'b1;
            len_next = len_reg + ipq_pkg::LEN_W'(1);
        end
        else if (pop_ok)
        begin
            pending_next[head_vec] = 1'b0;
            len_next = len_reg - ipq_pkg::LEN_W'(1);
        end
        else if (clr_ok)
        begin
            pending_next[vector_number] = 1'b0;
            len_next = len_reg - ipq_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            len_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            len_reg     <= len_next;
        end
    end

    // Build the result of this transfer
    assign res.popped_vector = pop_ok ? head_vec : '0;
    assign res.done_res      = push_ok || pop_ok || clr_ok;
    assign res.pending_count = len_next;

    ipq_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (accept),
        .wr_data   (res),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign popped_vector = out_res.popped_vector;
    assign done_res      = out_res.done_res;
    assign pending_count = out_res.pending_count;

    // Pending bits, cell occupancy and length agree
    a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pending_reg) == len_reg)
        else $error("pending bit count differs from list length");

    a_cells_len: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == len_reg)
        else $error("occupied cell count differs from list length");

    // Occupied cells form one run from the head
    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + ipq_pkg::LIST_DEPTH'(1))) == '0)
        else $error("gap in occupied cells");

    // A popped vector is no longer pending
    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok |=> !pending_reg[$past(head_vec)])
        else $error("popped vector still pending");

endmodule

@@ sv/ipq_cell.sv @@
// One slot of the sorted list: holds an entry and shifts left or right with its neighbors.
module ipq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ipq_pkg::cmd_t      cmd,
    input  ipq_pkg::prio_cfg_t prio_cfg,
    input  ipq_pkg::entry_t    left_in,
    input  ipq_pkg::entry_t    right_in,
    input  logic               ins_in,
    output logic               ins_out,
    input  logic               rm_in,
    output logic               rm_out,
    output ipq_pkg::entry_t    slot
);

    logic            valid_reg;
    logic            valid_next;
    logic [ipq_pkg::VEC_W-1:0] vec_reg;
    logic [ipq_pkg::VEC_W-1:0] vec_next;
    ipq_pkg::prio_t  my_prio;
    logic            gt;
    logic            here;
    logic            match;

    // Compare own entry against the new item
    assign my_prio = ipq_pkg::prio_of(prio_cfg, vec_reg);
    assign gt      = valid_reg && (my_prio > cmd.prio);
    assign here    = gt || !valid_reg;
    assign match   = valid_reg && (vec_reg == cmd.vec);
    assign ins_out = ins_in || here;
    assign rm_out  = rm_in || match;

    // Pick the next entry: shift right on insert, shift left on remove
    always_comb
    begin
        valid_next = valid_reg;
        vec_next   = vec_reg;
        if (cmd.push)
        begin
            if (ins_in)
            begin
                valid_next = left_in.valid;
                vec_next   = left_in.vec;
            end
            else if (here)
            begin
                valid_next = 1'b1;
                vec_next   = cmd.vec;
            end
        end
        else if (cmd.pop || (cmd.clear && rm_out))
        begin
            valid_next = right_in.valid;
            vec_next   = right_in.vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign slot.valid = valid_reg;
    assign slot.vec   = vec_reg;

endmodule

@@ sv/ipq_skid.sv @@
// Two-entry result buffer between the list update and the output channel.
module ipq_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  ipq_pkg::result_t wr_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output ipq_pkg::result_t out_data
);

    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    ipq_pkg::result_t slot0_reg;
    ipq_pkg::result_t slot0_next;
    ipq_pkg::result_t slot1_reg;
    ipq_pkg::result_t slot1_next;
    logic             rd;

    assign rd        = (cnt_reg != 2'd0) && !out_stall;
    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot0_reg;

    // Advance the buffer on write and read
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case ({wr, rd})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    slot0_next = wr_data;
                else
                    slot1_next = wr_data;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                slot0_next = (cnt_reg == 2'd1) ? wr_data : slot1_reg;
                slot1_next = wr_data;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the pending interrupt priority queue: scoreboard class and top.

// Tracks the pending list as the block should hold it and checks every result
class pending_queue_scoreboard;
    logic [ipq_pkg::CFG_W-1:0]         prio_low_reg;
    logic [ipq_pkg::CFG_W-1:0]         prio_high_reg;
    logic [ipq_pkg::VEC_W-1:0]         order_q [ipq_pkg::LIST_DEPTH];
    int                                listed;
    logic [ipq_pkg::NUM_VECTORS-1:0]   pending;
    ipq_pkg::result_t                  awaited [$];
    int                                mismatches;

    function new();
        prio_low_reg  = '0;
        prio_high_reg = '0;
        listed        = 0;
        pending       = '0;
        mismatches    = 0;
    endfunction

    function void write_register(input logic [ipq_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [ipq_pkg::CFG_W-1:0] data);
        if (idx == ipq_pkg::CFG_PRIO_LOW)
            prio_low_reg = data;
        else
            prio_high_reg = data;
    endfunction

    // Priority of a vector under the current register values
    function logic [ipq_pkg::PRIORITY_BITS-1:0] urgency(input logic [ipq_pkg::VEC_W-1:0] vec);
        logic [ipq_pkg::CFG_W-1:0] word;
        logic [3:0]                field;
        word  = vec[4] ? prio_high_reg : prio_low_reg;
        field = word[{vec[3:0], 2'b00} +: 4];
        return field[ipq_pkg::PRIORITY_BITS-1:0];
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_request(input logic [1:0] kind, input logic [ipq_pkg::VEC_W-1:0] vec);
        ipq_pkg::result_t                   r;
        logic [ipq_pkg::PRIORITY_BITS-1:0]  p;
        int                                 pos;
        int                                 i;
        r = '0;
        case (kind)
            ipq_pkg::OP_PUSH:
            begin
                if (int'(vec) < ipq_pkg::NUM_VECTORS && !pending[vec]
                    && listed < ipq_pkg::LIST_DEPTH)
                begin
                    // insert ahead of the first strictly less urgent entry
                    p   = urgency(vec);
                    pos = listed;
                    for (i = 0; i < listed; i++)
                    begin
                        if (urgency(order_q[i]) > p)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = listed; i > pos; i--)
                        order_q[i] = order_q[i-1];
                    order_q[pos] = vec;
                    listed++;
                    pending[vec] = 1'b1;
                    r.done_res   = 1'b1;
                end
            end
            ipq_pkg::OP_POP:
            begin
                if (listed > 0)
                begin
                    r.popped_vector = order_q[0];
                    for (i = 1; i < listed; i++)
                        order_q[i-1] = order_q[i];
                    listed--;
                    pending[r.popped_vector] = 1'b0;
                    r.done_res = 1'b1;
                end
            end
            ipq_pkg::OP_CLEAR:
            begin
                if (int'(vec) < ipq_pkg::NUM_VECTORS && pending[vec])
                begin
                    pending[vec] = 1'b0;
                    pos = -1;
                    for (i = 0; i < listed; i++)
                    begin
                        if (order_q[i] == vec)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos >= 0)
                    begin
                        for (i = pos + 1; i < listed; i++)
                            order_q[i-1] = order_q[i];
                        listed--;
                    end
                    r.done_res = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.pending_count = ipq_pkg::LEN_W'(listed);
        awaited.push_back(r);
    endfunction

    // Compare one output transfer with the oldest awaited result
    function void check_result(input logic [ipq_pkg::VEC_W-1:0] popped,
                               input logic done,
                               input logic [ipq_pkg::LEN_W-1:0] count);
        ipq_pkg::result_t exp;
        if (awaited.size() == 0)
        begin
            $error("result transfer with no result awaited");
            mismatches++;
            return;
        end
        exp = awaited.pop_front();
        if (popped !== exp.popped_vector)
        begin
            $error("popped_vector expected %0d actual %0d", exp.popped_vector, popped);
            mismatches++;
        end
        if (done !== exp.done_res)
        begin
            $error("done_res expected %0d actual %0d", exp.done_res, done);
            mismatches++;
        end
        if (count !== exp.pending_count)
        begin
            $error("pending_count expected %0d actual %0d", exp.pending_count, count);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return awaited.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         PHASE_COUNT    = 8;
    localparam int         PHASE_ITEMS    = 142;
    localparam int         STRETCH_ITEMS  = 40;
    localparam logic [ipq_pkg::CFG_W-1:0] ALL_ONES = {ipq_pkg::CFG_W{1'b1}};

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            in_valid      = 1'b0;
    logic                            in_stall;
    logic [1:0]                      op            = ipq_pkg::OP_PUSH;
    logic [ipq_pkg::VEC_W-1:0]       vector_number = '0;
    logic                            out_valid;
    logic                            out_stall     = 1'b0;
    logic [ipq_pkg::VEC_W-1:0]       popped_vector;
    logic                            done_res;
    logic [ipq_pkg::LEN_W-1:0]       pending_count;
    logic                            cfg_we        = 1'b0;
    logic [ipq_pkg::CFG_IDX_W-1:0]   cfg_index     = ipq_pkg::CFG_PRIO_LOW;
    logic [ipq_pkg::CFG_W-1:0]       cfg_data      = '0;

    int                     sender_pct    = 0;
    int                     receiver_pct  = 0;
    int                     cycle_count   = 0;

    pending_queue_scoreboard sb = new();

    irq_pending_priority_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .vector_number (vector_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .popped_vector (popped_vector),
        .done_res      (done_res),
        .pending_count (pending_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Run the clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stall the output at random
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < receiver_pct);

    // Check each output transfer
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(popped_vector, done_res, pending_count);

    // Present one item, idling first at random, and hold it until the transfer
    task send_item(input logic [1:0] kind, input logic [ipq_pkg::VEC_W-1:0] vec);
        while ($urandom_range(0, 99) < sender_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        op            <= kind;
        vector_number <= vec;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(kind, vec);
    endtask

    // Drop valid after the last item of a burst
    task end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Hold off until every awaited result has come, then let the pipe settle
    task wait_drained();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_cfg(input logic [ipq_pkg::CFG_IDX_W-1:0] idx,
                   input logic [ipq_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Choose an operation, biased toward filling or toward emptying the list
    function logic [1:0] pick_op(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < (filling ? 60 : 25))
            return ipq_pkg::OP_PUSH;
        else if (r < (filling ? 80 : 75))
            return ipq_pkg::OP_POP;
        else if (r < 95)
            return ipq_pkg::OP_CLEAR;
        else
            return OP_UNUSED;
    endfunction

    initial
    begin
        logic [ipq_pkg::CFG_W-1:0] low_word;
        logic [ipq_pkg::CFG_W-1:0] high_word;
        int                        ph;
        int                        n;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset priorities are all equal, so the list runs first in, first out
        send_item(ipq_pkg::OP_POP,   5'd0);
        send_item(ipq_pkg::OP_CLEAR, 5'd5);
        send_item(OP_UNUSED,         5'd31);
        send_item(ipq_pkg::OP_PUSH,  5'd0);
        send_item(ipq_pkg::OP_PUSH,  5'd31);
        send_item(ipq_pkg::OP_PUSH,  5'd0);
        send_item(ipq_pkg::OP_PUSH,  5'd17);
        send_item(ipq_pkg::OP_CLEAR, 5'd31);
        send_item(ipq_pkg::OP_CLEAR, 5'd31);
        send_item(ipq_pkg::OP_POP,   5'd31);
        send_item(ipq_pkg::OP_POP,   5'd0);
        send_item(ipq_pkg::OP_POP,   5'd0);
        send_item(ipq_pkg::OP_PUSH,  5'd31);
        send_item(ipq_pkg::OP_PUSH,  5'd16);
        send_item(ipq_pkg::OP_PUSH,  5'd15);
        send_item(OP_UNUSED,         5'd0);
        send_item(ipq_pkg::OP_CLEAR, 5'd16);
        send_item(ipq_pkg::OP_POP,   5'd0);
        send_item(ipq_pkg::OP_POP,   5'd0);
        end_burst();
        wait_drained();

        // Random phases; each sets the priority registers and picks an idling mode
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: begin low_word = '0;       high_word = '0;       end
                1: begin low_word = ALL_ONES; high_word = ALL_ONES; end
                2: begin low_word = ALL_ONES; high_word = '0;       end
                4: begin low_word = '0;       high_word = ALL_ONES; end
                5:
                begin
                    low_word  = {$urandom, $urandom} & {16{4'h1}};
                    high_word = {$urandom, $urandom} & {16{4'h1}};
                end
                6:
                begin
                    low_word  = 64'hFEDC_BA98_7654_3210;
                    high_word = 64'h0123_4567_89AB_CDEF;
                end
                default:
                begin
                    low_word  = {$urandom, $urandom};
                    high_word = {$urandom, $urandom};
                end
            endcase
            write_cfg(ipq_pkg::CFG_PRIO_LOW, low_word);
            write_cfg(ipq_pkg::CFG_PRIO_HIGH, high_word);

            case (ph % 4)
                0: begin sender_pct = 0;  receiver_pct = 0;  end
                1: begin sender_pct = 82; receiver_pct = 0;  end
                2: begin sender_pct = 0;  receiver_pct = 82; end
                default: begin sender_pct = 33; receiver_pct = 33; end
            endcase

            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_op(((n / STRETCH_ITEMS) % 2) == 0), 5'($urandom_range(0, 31)));
            end_burst();
            wait_drained();
        end

        sender_pct   = 0;
        receiver_pct = 0;
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ files.f @@
sv/ipq_pkg.sv
sv/ipq_cell.sv
sv/ipq_skid.sv
sv/irq_pending_priority_queue.sv
tb/sv/testbench.sv
